@@ design/kcvlt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kcvlt_pkg: shared types and constants of the line tokenizer
// Event codes, character codes, the result word layout and whitespace test.
// ----------------------------------------------------------------------------
package kcvlt_pkg;

	localparam int MAX_LINE_DEF = 256;
	localparam int RESULT_W     = 96;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef enum logic [1:0] {
		EVT_PAIR = 2'd0,
		EVT_CONT = 2'd1,
		EVT_ERR  = 2'd2
	} event_kind_t;

	typedef struct packed {
		logic [31:0] first_error_line;
		logic [7:0]  value_len;
		logic [7:0]  value_start;
		logic [7:0]  name_len;
		logic [7:0]  name_start;
		logic [31:0] line_number;
		event_kind_t kind;
	} event_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

endpackage
`default_nettype wire

@@ design/kcvlt_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kcvlt_scan: per-line state and event decision
// Holds line and stream state, advances it by one byte per step and forms
// the event of a line that closes on that step.
// ----------------------------------------------------------------------------
module kcvlt_scan import kcvlt_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] char_byte,
	input  wire logic       end_of_stream,
	input  wire logic       stop_on_error,
	output logic            evt_valid,
	output event_t          evt
);

	localparam int CW = $clog2(MAX_LINE);
	localparam logic [CW-1:0] LAST_COL = CW'(MAX_LINE - 1);

	typedef enum logic [2:0] {
		PH_LEAD, PH_COMMENT, PH_CONT, PH_NAME, PH_BAD, PH_VLEAD, PH_VALUE, PH_VDONE
	} phase_t;

	typedef struct packed {
		phase_t        phase;
		logic          lead_ws;
		logic          prev_ws;
		logic          name_present;
		logic          text_cut;
		logic [CW-1:0] column;
		logic [CW-1:0] text_col;
		logic [CW-1:0] name_last;
		logic [CW-1:0] val_first;
		logic [CW-1:0] val_last;
	} line_t;

	localparam line_t LINE_CLEAR = '{phase: PH_LEAD, default: '0};

	line_t       line_q, line_n;
	logic [31:0] line_cnt_q, line_cnt_n;
	logic [31:0] err_line_q, err_line_n;
	logic        prior_name_q, prior_name_n;
	logic        halted_q, halted_n;

	logic          do_close;
	logic          ws;
	logic [CW-1:0] col;

	always_comb begin
		line_n       = line_q;
		line_cnt_n   = line_cnt_q;
		err_line_n   = err_line_q;
		prior_name_n = prior_name_q;
		halted_n     = halted_q;
		do_close     = 1'b0;
		evt_valid    = 1'b0;
		evt          = '0;
		col          = line_q.column;
		ws           = is_ws(char_byte);

		if (end_of_stream) begin
			do_close = !halted_q && (col != '0);
		end else if (!halted_q) begin
			line_n.column = col + 1'b1;
			if (char_byte == CH_LF) begin
				do_close = 1'b1;
			end else begin
				if (!line_q.text_cut) begin
					if (char_byte == CH_NUL) begin
						line_n.text_cut = 1'b1;
					end else begin
						unique case (line_q.phase)
							PH_LEAD: begin
								if (ws) begin
									line_n.lead_ws = 1'b1;
								end else begin
									line_n.text_col = col;
									priority if (char_byte == CH_HASH) begin
										line_n.phase = PH_COMMENT;
									end else if (prior_name_q && line_q.lead_ws) begin
										line_n.val_first = col;
										line_n.val_last  = col;
										line_n.phase     = PH_CONT;
									end else if (char_byte == CH_COLON) begin
										line_n.name_present = 1'b0;
										line_n.phase        = PH_VLEAD;
									end else begin
										line_n.name_present = 1'b1;
										line_n.name_last    = col;
										line_n.prev_ws      = 1'b0;
										line_n.phase        = PH_NAME;
									end
								end
							end
							PH_CONT: begin
								if (!ws) line_n.val_last = col;
							end
							PH_NAME: begin
								priority if (char_byte == CH_COLON) begin
									line_n.phase = PH_VLEAD;
								end else if (char_byte == CH_HASH && line_q.prev_ws) begin
									line_n.phase = PH_BAD;
								end else begin
									if (!ws) line_n.name_last = col;
									line_n.prev_ws = ws;
								end
							end
							PH_VLEAD: begin
								if (!ws) begin
									line_n.val_first = col;
									line_n.val_last  = col;
									line_n.prev_ws   = 1'b0;
									line_n.phase     = PH_VALUE;
								end
							end
							PH_VALUE: begin
								if (char_byte == CH_HASH && line_q.prev_ws) begin
									line_n.phase = PH_VDONE;
								end else begin
									if (!ws) line_n.val_last = col;
									line_n.prev_ws = ws;
								end
							end
							default: begin
							end
						endcase
					end
				end
				if (line_n.column >= LAST_COL) do_close = 1'b1;
			end
		end

		if (do_close) begin
			if (line_cnt_n != '1) line_cnt_n = line_cnt_n + 32'd1;
			unique case (line_n.phase)
				PH_CONT: begin
					evt_valid       = 1'b1;
					evt.kind        = EVT_CONT;
					evt.value_start = 8'(line_n.val_first);
					evt.value_len   = 8'(line_n.val_last - line_n.val_first + 1'b1);
				end
				PH_NAME, PH_BAD: begin
					evt_valid = 1'b1;
					evt.kind  = EVT_ERR;
					if (err_line_n == '0) err_line_n = line_cnt_n;
				end
				PH_VLEAD, PH_VALUE, PH_VDONE: begin
					evt_valid = 1'b1;
					evt.kind  = EVT_PAIR;
					if (line_n.name_present) begin
						evt.name_start = 8'(line_n.text_col);
						evt.name_len   = 8'(line_n.name_last - line_n.text_col + 1'b1);
					end
					if (line_n.phase != PH_VLEAD) begin
						evt.value_start = 8'(line_n.val_first);
						evt.value_len   = 8'(line_n.val_last - line_n.val_first + 1'b1);
					end
					prior_name_n = line_n.name_present;
				end
				default: begin
				end
			endcase
			evt.line_number      = line_cnt_n;
			evt.first_error_line = err_line_n;
			line_n   = LINE_CLEAR;
			halted_n = stop_on_error && (err_line_n != '0);
		end

		if (end_of_stream) begin
			line_n       = LINE_CLEAR;
			line_cnt_n   = '0;
			err_line_n   = '0;
			prior_name_n = 1'b0;
			halted_n     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q       <= LINE_CLEAR;
			line_cnt_q   <= '0;
			err_line_q   <= '0;
			prior_name_q <= 1'b0;
			halted_q     <= 1'b0;
		end else if (step) begin
			line_q       <= line_n;
			line_cnt_q   <= line_cnt_n;
			err_line_q   <= err_line_n;
			prior_name_q <= prior_name_n;
			halted_q     <= halted_n;
		end
	end

endmodule
`default_nettype wire

@@ design/key_colon_value_line_tokenizer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// key_colon_value_line_tokenizer_top: name:value text line tokenizer
// Streams text bytes in and emits one event word per reported line.
// ----------------------------------------------------------------------------
// One input word is taken every clock cycle while the result side keeps up.
// A word is registered on acceptance; when the output side can advance, the
// line state is updated from it and, at that same edge, any event of a line
// that it closes lands in the output register. The line scanner takes one
// word per step, which sets the rate of one word per cycle while the result
// side keeps up. Write stop_on_error only while no word is in flight.
module key_colon_value_line_tokenizer_top import kcvlt_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,  // char_byte
	input  wire logic                s_tlast,  // end_of_stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// line_number, name_start, name_len, value_start, value_len, first_error_line
	output logic [RESULT_W-1:0]      m_tdata,
	output logic [1:0]               m_tuser   // event_kind
);

	logic       stop_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       out_valid_q;
	event_t     out_q;
	logic       advance;
	logic       step;
	logic       evt_valid;
	event_t     evt;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q      <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) stop_q <= cfg_wdata;
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) out_valid_q <= step && evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
		if (step && evt_valid) out_q <= evt;
	end

	kcvlt_scan #(
		.MAX_LINE(MAX_LINE)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.char_byte    (byte_s1),
		.end_of_stream(eos_s1),
		.stop_on_error(stop_q),
		.evt_valid    (evt_valid),
		.evt          (evt)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {out_q.first_error_line, out_q.value_len, out_q.value_start,
		out_q.name_len, out_q.name_start, out_q.line_number};

	a_err_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == EVT_ERR |->
			out_q.first_error_line != '0 && out_q.first_error_line <= out_q.line_number)
		else $error("error event without a recorded error line");

	a_err_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.first_error_line <= out_q.line_number)
		else $error("first error line beyond current line");

	a_cont_no_name: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind != EVT_PAIR |->
			out_q.name_len == '0 && out_q.name_start == '0)
		else $error("name reported on a non-pair event");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

endmodule
`default_nettype wire

@@ dv/kcvlt_text_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kcvlt_text_pkg: whitespace character codes for the tokenizer testbench
// Codes shared by the stimulus and the event checker.
// ----------------------------------------------------------------------------
package kcvlt_text_pkg;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

endpackage
`default_nettype wire

@@ dv/kcvlt_event_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kcvlt_event_checker: line event predictor and scoreboard
// Watches the byte, event and config channels, rebuilds the line scanner
// state per accepted word, and compares every event word field by field.
// ----------------------------------------------------------------------------
module kcvlt_event_checker import kcvlt_pkg::*, kcvlt_text_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	input  wire logic [7:0]          s_tdata,
	input  wire logic                s_tlast,
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	input  wire logic [RESULT_W-1:0] m_tdata,
	input  wire logic [1:0]          m_tuser,
	output int                       pending,
	output int                       mismatches,
	output int                       events_checked
);

	typedef enum logic [2:0] {
		SC_LEAD, SC_COMMENT, SC_CONT, SC_NAME, SC_BAD, SC_VLEAD, SC_VALUE, SC_VDONE
	} scan_t;

	event_t      expected_events[$];
	int          fail_count = 0;
	int          checked_count = 0;
	int          queued_count = 0;

	bit          stop_cfg;
	int unsigned col;
	logic [31:0] lines;
	scan_t       sc;
	bit          lead_ws, prev_ws, name_nonempty, cut, prior_name, halt;
	logic [7:0]  text_col, name_end, val_begin, val_end;
	logic [31:0] err_line;

	assign pending        = queued_count;
	assign mismatches     = fail_count;
	assign events_checked = checked_count;

	function automatic bit blank_char(input logic [7:0] c);
		return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic void clear_line();
		col = 0;
		sc = SC_LEAD;
		lead_ws = 1'b0;
		prev_ws = 1'b0;
		text_col = '0;
		name_end = '0;
		val_begin = '0;
		val_end = '0;
		name_nonempty = 1'b0;
		cut = 1'b0;
	endfunction

	function automatic void clear_stream();
		clear_line();
		lines = '0;
		prior_name = 1'b0;
		err_line = '0;
		halt = 1'b0;
	endfunction

	function automatic void close_line_event();
		event_t ev;
		bit     hit;
		ev = '0;
		hit = 1'b0;
		if (lines != 32'hFFFF_FFFF)
			lines++;
		case (sc)
			SC_CONT: begin
				hit = 1'b1;
				ev.kind = EVT_CONT;
				ev.value_start = val_begin;
				ev.value_len = val_end - val_begin + 8'd1;
			end
			SC_NAME, SC_BAD: begin
				hit = 1'b1;
				ev.kind = EVT_ERR;
				if (err_line == '0)
					err_line = lines;
			end
			SC_VLEAD, SC_VALUE, SC_VDONE: begin
				hit = 1'b1;
				ev.kind = EVT_PAIR;
				if (name_nonempty) begin
					ev.name_start = text_col;
					ev.name_len = name_end - text_col + 8'd1;
				end
				if (sc != SC_VLEAD) begin
					ev.value_start = val_begin;
					ev.value_len = val_end - val_begin + 8'd1;
				end
				prior_name = name_nonempty;
			end
			default: ;
		endcase
		if (hit) begin
			ev.line_number = lines;
			ev.first_error_line = err_line;
			expected_events.push_back(ev);
		end
		clear_line();
		if (stop_cfg && err_line != '0)
			halt = 1'b1;
	endfunction

	function automatic void scan_char(input logic [7:0] c, input logic [7:0] at);
		bit ws;
		if (cut)
			return;
		if (c == CH_NUL) begin
			cut = 1'b1;
			return;
		end
		ws = blank_char(c);
		case (sc)
			SC_LEAD: begin
				if (ws) begin
					lead_ws = 1'b1;
				end else begin
					text_col = at;
					if (c == CH_HASH) begin
						sc = SC_COMMENT;
					end else if (prior_name && lead_ws) begin
						val_begin = at;
						val_end = at;
						sc = SC_CONT;
					end else if (c == CH_COLON) begin
						name_nonempty = 1'b0;
						sc = SC_VLEAD;
					end else begin
						name_nonempty = 1'b1;
						name_end = at;
						prev_ws = 1'b0;
						sc = SC_NAME;
					end
				end
			end
			SC_CONT: begin
				if (!ws)
					val_end = at;
			end
			SC_NAME: begin
				if (c == CH_COLON) begin
					sc = SC_VLEAD;
				end else if (c == CH_HASH && prev_ws) begin
					sc = SC_BAD;
				end else begin
					if (!ws)
						name_end = at;
					prev_ws = ws;
				end
			end
			SC_VLEAD: begin
				if (!ws) begin
					val_begin = at;
					val_end = at;
					prev_ws = 1'b0;
					sc = SC_VALUE;
				end
			end
			SC_VALUE: begin
				if (c == CH_HASH && prev_ws) begin
					sc = SC_VDONE;
				end else begin
					if (!ws)
						val_end = at;
					prev_ws = ws;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void predict_word(input logic [7:0] c, input logic eos);
		if (eos) begin
			if (!halt && col > 0)
				close_line_event();
			clear_stream();
			return;
		end
		if (halt)
			return;
		col++;
		if (c == CH_LF) begin
			close_line_event();
			return;
		end
		scan_char(c, 8'(col - 1));
		if (col >= MAX_LINE - 1)
			close_line_event();
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at event %0d: %s", checked_count, msg);
		fail_count++;
	endtask

	task automatic check_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", field, got, want));
	endtask

	task automatic check_event();
		event_t got, want;
		got = event_t'({m_tdata, m_tuser});
		if (expected_events.size() == 0) begin
			report_mismatch("event word with no line pending");
		end else begin
			want = expected_events.pop_front();
			check_field("event_kind", 32'(got.kind), 32'(want.kind));
			check_field("line_number", got.line_number, want.line_number);
			check_field("name_start", 32'(got.name_start), 32'(want.name_start));
			check_field("name_len", 32'(got.name_len), 32'(want.name_len));
			check_field("value_start", 32'(got.value_start), 32'(want.value_start));
			check_field("value_len", 32'(got.value_len), 32'(want.value_len));
			check_field("first_error_line", got.first_error_line, want.first_error_line);
		end
		checked_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_cfg = 1'b0;
			clear_stream();
			expected_events.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_event();
			if (cfg_we)
				stop_cfg = cfg_wdata;
			if (s_tvalid && s_tready)
				predict_word(s_tdata, s_tlast);
		end
		queued_count = expected_events.size();
	end

endmodule
`default_nettype wire

@@ dv/tb_key_colon_value_line_tokenizer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_key_colon_value_line_tokenizer_top: testbench of the line tokenizer
// Sends short directed lines, then random name:value text, continuations,
// comments, broken lines, zero bytes, long lines and raw noise, under both
// stop_on_error settings, with random gaps on the byte and event sides.
// ----------------------------------------------------------------------------
module tb_key_colon_value_line_tokenizer_top;
	import kcvlt_pkg::*;
	import kcvlt_text_pkg::*;

	localparam int LIMIT = 500000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic                cfg_wdata = 1'b0;
	logic                s_tvalid = 1'b0;
	wire logic           s_tready;
	logic [7:0]          s_tdata = '0;
	logic                s_tlast = 1'b0;
	wire logic           m_tvalid;
	logic                m_tready = 1'b0;
	wire logic [RESULT_W-1:0] m_tdata;
	wire logic [1:0]     m_tuser;

	int pending, mismatches, events_checked;
	int cycle_count = 0;
	int words_sent = 0;
	int streams_closed = 0;
	bit calm = 1'b0;

	always #10 clk = ~clk;

	key_colon_value_line_tokenizer_top #(.MAX_LINE(MAX_LINE_DEF)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	kcvlt_event_checker #(.MAX_LINE(MAX_LINE_DEF)) u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.pending(pending), .mismatches(mismatches), .events_checked(events_checked)
	);

	function automatic logic [7:0] ws_char();
		int r;
		r = $urandom_range(0, 4);
		if (r == 0)
			return CH_SP;
		if (r == 1)
			return CH_TAB;
		return CH_VT + 8'(r - 2);
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 126));
		while (c == CH_COLON || c == CH_HASH);
		return c;
	endfunction

	function automatic logic [7:0] value_char();
		case ($urandom_range(0, 9))
			0: return CH_COLON;
			1: return CH_HASH;
			2: return ws_char();
			default: return text_char();
		endcase
	endfunction

	task automatic send_word(input logic [7:0] b, input logic eos);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eos;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
		if (eos)
			streams_closed++;
	endtask

	task automatic send_line(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 1'b0);
		send_word(CH_LF, 1'b0);
	endtask

	task automatic write_stop(input logic v);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_long_line();
		repeat ($urandom_range(252, 258)) send_word(value_char(), 1'b0);
		send_word(CH_LF, 1'b0);
	endtask

	task automatic send_random_line(input bit stop_now);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			if ($urandom_range(0, 7) == 0)
				send_word(ws_char(), 1'b0);
			repeat ($urandom_range(0, 6)) send_word(text_char(), 1'b0);
			repeat ($urandom_range(0, 2)) send_word(ws_char(), 1'b0);
			send_word(CH_COLON, 1'b0);
			repeat ($urandom_range(0, 2)) send_word(ws_char(), 1'b0);
			repeat ($urandom_range(0, 8)) send_word(value_char(), 1'b0);
			if ($urandom_range(0, 3) == 0) begin
				send_word(ws_char(), 1'b0);
				send_word(CH_HASH, 1'b0);
				send_word(value_char(), 1'b0);
			end
		end else if (sel < 55) begin
			repeat ($urandom_range(1, 3)) send_word(ws_char(), 1'b0);
			repeat ($urandom_range(1, 8)) send_word(value_char(), 1'b0);
		end else if (sel < 62) begin
			repeat ($urandom_range(0, 2)) send_word(ws_char(), 1'b0);
			send_word(CH_HASH, 1'b0);
			repeat ($urandom_range(0, 6)) send_word(value_char(), 1'b0);
		end else if (sel < 69) begin
			repeat ($urandom_range(0, 3)) send_word(ws_char(), 1'b0);
		end else if (sel < 78) begin
			repeat ($urandom_range(1, 6)) send_word(text_char(), 1'b0);
			if ($urandom_range(0, 1) == 0) begin
				send_word(ws_char(), 1'b0);
				send_word(CH_HASH, 1'b0);
				send_word(CH_COLON, 1'b0);
			end
		end else if (sel < 85) begin
			repeat ($urandom_range(0, 3)) send_word(text_char(), 1'b0);
			if ($urandom_range(0, 1) == 0)
				send_word(CH_COLON, 1'b0);
			send_word(CH_NUL, 1'b0);
			repeat ($urandom_range(0, 5)) send_word(value_char(), 1'b0);
		end else if (sel < 99) begin
			repeat ($urandom_range(1, 10)) send_word(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_long_line();
		end
		if ($urandom_range(0, stop_now ? 5 : 19) == 0)
			send_word(8'($urandom_range(0, 255)), 1'b1);
		else
			send_word(CH_LF, 1'b0);
		if ($urandom_range(0, 29) == 0)
			send_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding", cycle_count, pending);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int target;
		bit stop_now;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_stop(1'b0);
		send_line(":#");
		send_line(" x");
		send_line("a:");
		send_line("\tv");
		send_line("#c");
		send_word(CH_LF, 1'b0);
		send_line("k #:");
		send_word(text_char(), 1'b0);
		send_word(CH_NUL, 1'b0);
		send_word(CH_COLON, 1'b0);
		send_word(CH_LF, 1'b0);
		send_word(8'hFF, 1'b1);
		send_word(8'h00, 1'b1);

		write_stop(1'b1);
		send_line("e");
		send_line("a:b");
		send_word(8'h00, 1'b1);
		send_line("p:q");

		for (int p = 0; p < 4; p++) begin
			stop_now = p[0];
			write_stop(stop_now);
			if (!stop_now)
				send_long_line();
			target = words_sent + 160;
			while (words_sent < target) begin
				if (p == 3 && words_sent >= target - 120)
					calm = 1'b1;
				send_random_line(stop_now);
			end
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
		$display("summary: %0d bytes in %0d closed streams, %0d line events checked",
			words_sent, streams_closed, events_checked);
		$display("summary: stop_on_error 0 and 1, comments, continuations, zero bytes, long lines");
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
